// File: hdl/transitive_closure_engine_top_macros.svh
// Assertion macros for the transitive closure engine checker
`ifndef TRANSITIVE_CLOSURE_ENGINE_TOP_MACROS_SVH
`define TRANSITIVE_CLOSURE_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define TCE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define TCE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/tce_pkg.sv
// Shared constants and command codes of the transitive closure engine
package tce_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int ROW_W        = MAX_VERTICES;
    localparam int IDX_W        = 4;
    localparam int CNT_W        = 5;
    localparam int CMD_W        = 2;

    localparam logic [CNT_W-1:0] VCOUNT_RESET = CNT_W'(16);
    localparam logic [CNT_W-1:0] VCOUNT_MAX   = CNT_W'(MAX_VERTICES);

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD_EDGE = 2'd0,
        CMD_CLOSURE  = 2'd1,
        CMD_QUERY    = 2'd2
    } t_cmd;

endpackage

// File: hdl/transitive_closure_engine_top.sv
// Transitive closure engine: adjacency matrix in a row memory with a command sequencer
//
// The graph lives in a 16-row by 16-bit memory, one row per source vertex, read through a
// registered port and written back by a sequencer; rows never written since reset read as
// zero through per-row valid bits, so no clearing pass is needed. Every command returns one
// word. Add edge and query read the row, modify or pick the bit, then load the output
// register; a rejected or unknown command goes straight to loading the output register.
// Closure makes one pass that sets the diagonal, then for each pivot loads the pivot row and
// sweeps the rows, since the single memory read and write port handles one row per cycle.
// One command is in flight at a time; the next is taken while the previous result still
// waits in the output register.
module transitive_closure_engine_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [tce_pkg::CNT_W-1:0]    i_cfg_wr_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [tce_pkg::CMD_W-1:0]    i_command,
    input  logic [tce_pkg::IDX_W-1:0]    i_src_vertex,
    input  logic [tce_pkg::IDX_W-1:0]    i_dst_vertex,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_edge_present,
    output logic                         o_status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIAG,
        ST_PIV,
        ST_ROW,
        ST_DONE
    } t_state;

    // row memory and its valid bits
    logic [tce_pkg::ROW_W-1:0] r_mem [tce_pkg::MAX_VERTICES];
    logic [tce_pkg::MAX_VERTICES-1:0] r_row_vld;
    logic [tce_pkg::ROW_W-1:0] r_rd_data;
    logic                      r_rd_vld;
    logic                      r_byp;
    logic [tce_pkg::ROW_W-1:0] r_byp_data;

    logic                      mem_rd_en;
    logic [tce_pkg::IDX_W-1:0] mem_rd_addr;
    logic                      mem_wr_en;
    logic [tce_pkg::IDX_W-1:0] mem_wr_addr;
    logic [tce_pkg::ROW_W-1:0] mem_wr_data;
    logic [tce_pkg::ROW_W-1:0] rd_row;

    // control and payload registers
    t_state                    r_state, n_state;
    logic [tce_pkg::CNT_W-1:0] r_vcount;
    logic [tce_pkg::CMD_W-1:0] r_cmd, n_cmd;
    logic [tce_pkg::IDX_W-1:0] r_src, n_src;
    logic [tce_pkg::IDX_W-1:0] r_dst, n_dst;
    logic [tce_pkg::IDX_W-1:0] r_row, n_row;
    logic [tce_pkg::IDX_W-1:0] r_piv_idx, n_piv_idx;
    logic [tce_pkg::ROW_W-1:0] r_pivot, n_pivot;
    logic                      r_res_present, n_res_present;
    logic                      r_res_status, n_res_status;
    logic                      r_out_valid, n_out_valid;
    logic                      r_edge_present, n_edge_present;
    logic                      r_status, n_status;

    logic [tce_pkg::CNT_W-1:0] n_active;
    logic [tce_pkg::CNT_W-1:0] last_idx;
    logic [tce_pkg::ROW_W-1:0] col_mask;
    logic                      in_range;
    logic                      row_last;
    logic                      piv_last;

    // effective vertex count saturates at the matrix size
    assign n_active = (r_vcount > tce_pkg::VCOUNT_MAX) ? tce_pkg::VCOUNT_MAX : r_vcount;
    assign last_idx = n_active - tce_pkg::CNT_W'(1);
    assign row_last = ({1'b0, r_row} == last_idx);
    assign piv_last = ({1'b0, r_piv_idx} == last_idx);
    assign in_range = ({1'b0, i_src_vertex} < n_active) && ({1'b0, i_dst_vertex} < n_active);

    always_comb begin
        for (int j = 0; j < tce_pkg::ROW_W; j++) begin
            col_mask[j] = (tce_pkg::CNT_W'(j) < n_active);
        end
    end

    // forward a same-cycle write, and read never-written rows as zero
    assign rd_row = r_byp ? r_byp_data : (r_rd_vld ? r_rd_data : '0);

    always_ff @(posedge i_clk) begin
        if (mem_wr_en) begin
            r_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en) begin
            r_rd_data  <= r_mem[mem_rd_addr];
            r_rd_vld   <= r_row_vld[mem_rd_addr];
            r_byp      <= mem_wr_en && (mem_wr_addr == mem_rd_addr);
            r_byp_data <= mem_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (mem_wr_en) begin
            r_row_vld[mem_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= tce_pkg::VCOUNT_RESET;
        end else if (i_cfg_wr_en) begin
            r_vcount <= i_cfg_wr_data;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_cmd          = r_cmd;
        n_src          = r_src;
        n_dst          = r_dst;
        n_row          = r_row;
        n_piv_idx      = r_piv_idx;
        n_pivot        = r_pivot;
        n_res_present  = r_res_present;
        n_res_status   = r_res_status;
        n_out_valid    = r_out_valid;
        n_edge_present = r_edge_present;
        n_status       = r_status;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = '0;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = '0;
        mem_wr_data    = '0;

        // drop the output word once taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_cmd         = i_command;
                    n_src         = i_src_vertex;
                    n_dst         = i_dst_vertex;
                    n_res_present = 1'b0;
                    n_res_status  = 1'b0;
                    unique case (i_command) inside
                        tce_pkg::CMD_ADD_EDGE, tce_pkg::CMD_QUERY: begin
                            if (in_range) begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = i_src_vertex;
                                n_state     = ST_ACC;
                            end else begin
                                n_res_status = 1'b1;
                                n_state      = ST_DONE;
                            end
                        end
                        tce_pkg::CMD_CLOSURE: begin
                            if (n_active == '0) begin
                                n_state = ST_DONE;
                            end else begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = '0;
                                n_row       = '0;
                                n_state     = ST_DIAG;
                            end
                        end
                        default: begin
                            n_res_status = 1'b1;
                            n_state      = ST_DONE;
                        end
                    endcase
                end
            end
            ST_ACC: begin
                if (r_cmd == tce_pkg::CMD_ADD_EDGE) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = r_src;
                    mem_wr_data = rd_row | (tce_pkg::ROW_W'(1) << r_dst);
                end else begin
                    n_res_present = rd_row[r_dst];
                end
                n_state = ST_DONE;
            end
            ST_DIAG: begin
                // set the diagonal bit, read the next row behind it
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_row;
                mem_wr_data = rd_row | (tce_pkg::ROW_W'(1) << r_row);
                mem_rd_en   = 1'b1;
                if (row_last) begin
                    n_piv_idx   = '0;
                    mem_rd_addr = '0;
                    n_state     = ST_PIV;
                end else begin
                    n_row       = r_row + tce_pkg::IDX_W'(1);
                    mem_rd_addr = n_row;
                end
            end
            ST_PIV: begin
                n_pivot     = rd_row & col_mask;
                n_row       = '0;
                mem_rd_en   = 1'b1;
                mem_rd_addr = '0;
                n_state     = ST_ROW;
            end
            ST_ROW: begin
                if (rd_row[r_piv_idx]) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = r_row;
                    mem_wr_data = rd_row | r_pivot;
                end
                if (row_last) begin
                    if (piv_last) begin
                        n_state = ST_DONE;
                    end else begin
                        n_piv_idx   = r_piv_idx + tce_pkg::IDX_W'(1);
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = n_piv_idx;
                        n_state     = ST_PIV;
                    end
                end else begin
                    n_row       = r_row + tce_pkg::IDX_W'(1);
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = n_row;
                end
            end
            ST_DONE: begin
                // hold the result until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid    = 1'b1;
                    n_edge_present = r_res_present;
                    n_status       = r_res_status;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_cmd          <= n_cmd;
        r_src          <= n_src;
        r_dst          <= n_dst;
        r_row          <= n_row;
        r_piv_idx      <= n_piv_idx;
        r_pivot        <= n_pivot;
        r_res_present  <= n_res_present;
        r_res_status   <= n_res_status;
        r_edge_present <= n_edge_present;
        r_status       <= n_status;
    end

    assign o_in_ready     = (r_state == ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_edge_present = r_edge_present;
    assign o_status       = r_status;

endmodule

// File: hdl/tce_checker.sv
// Port-level checker for the transitive closure engine and its bind
`include "transitive_closure_engine_top_macros.svh"

module tce_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic o_edge_present,
    input logic o_status
);

    `TCE_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid, "output word dropped")
    `TCE_ASSERT_NEXT(a_out_stable, o_out_valid && !i_out_ready, $stable(o_edge_present) && $stable(o_status), "output word changed while stalled")
    `TCE_ASSERT_NEXT(a_one_in_flight, i_in_valid && o_in_ready, !o_in_ready, "second command taken while one is in flight")
    `TCE_ASSERT_SAME(a_result_frees, $rose(o_out_valid), o_in_ready, "result shown but sequencer not idle")

endmodule

bind transitive_closure_engine_top tce_checker u_tce_checker (.*);

// File: tb/tb_transitive_closure_engine_top.sv
// Self-checking testbench for the transitive closure engine: directed table, then random traffic
`timescale 1ns / 100ps

module tb_transitive_closure_engine_top;

    localparam logic [tce_pkg::CMD_W-1:0] CMD_UNUSED  = 2'd3;
    localparam int                        CYCLE_LIMIT = 1000000;
    localparam int                        PHASES      = 12;
    localparam int                        PHASE_ITEMS = 50;

    typedef struct packed {
        logic edge_present;
        logic status;
    } t_answer;

    typedef struct packed {
        bit                        is_cfg;
        logic [tce_pkg::CNT_W-1:0] count;
        logic [tce_pkg::CMD_W-1:0] cmd;
        logic [tce_pkg::IDX_W-1:0] src;
        logic [tce_pkg::IDX_W-1:0] dst;
        bit                        known;
        logic                      present;
        logic                      status;
    } t_script_row;

    logic                        i_clk;
    logic                        i_rst_n        = 1'b0;
    logic                        i_cfg_wr_en    = 1'b0;
    logic [tce_pkg::CNT_W-1:0]   i_cfg_wr_data  = '0;
    logic                        i_in_valid     = 1'b0;
    logic                        o_in_ready;
    logic [tce_pkg::CMD_W-1:0]   i_command      = tce_pkg::CMD_ADD_EDGE;
    logic [tce_pkg::IDX_W-1:0]   i_src_vertex   = '0;
    logic [tce_pkg::IDX_W-1:0]   i_dst_vertex   = '0;
    logic                        o_out_valid;
    logic                        i_out_ready    = 1'b0;
    logic                        o_edge_present;
    logic                        o_status;

    // shadow of the graph and of the vertex count register
    logic [tce_pkg::ROW_W-1:0]   reach_rows [tce_pkg::MAX_VERTICES];
    logic [tce_pkg::CNT_W-1:0]   vertex_reg;
    t_answer                     pending_answers [$];

    bit                 stall_on    = 1'b1;
    int                 calm_left   = 0;
    int                 mismatches  = 0;
    int                 words_sent  = 0;
    int                 words_seen  = 0;
    int                 closures    = 0;
    int                 flagged     = 0;
    int                 cycle_count = 0;

    t_script_row directed_script [29] = '{
        '{1'b0, 5'd0,  tce_pkg::CMD_QUERY,    4'd0,  4'd0,  1'b1, 1'b0, 1'b0},
        '{1'b0, 5'd0,  tce_pkg::CMD_QUERY,    4'd15, 4'd15, 1'b1, 1'b0, 1'b0},
        '{1'b0, 5'd0,  tce_pkg::CMD_ADD_EDGE, 4'd15, 4'd0,  1'b1, 1'b0, 1'b0},
        '{1'b0, 5'd0,  tce_pkg::CMD_ADD_EDGE, 4'd0,  4'd15, 1'b1, 1'b0, 1'b0},
        '{1'b0, 5'd0,  tce_pkg::CMD_QUERY,    4'd15, 4'd0,  1'b1, 1'b1, 1'b0},
        '{1'b0, 5'd0,  tce_pkg::CMD_QUERY,    4'd0,  4'd0,  1'b1, 1'b0, 1'b0},
        '{1'b0, 5'd0,  CMD_UNUSED,            4'd15, 4'd15, 1'b1, 1'b0, 1'b1},
        '{1'b0, 5'd0,  tce_pkg::CMD_CLOSURE,  4'd0,  4'd0,  1'b1, 1'b0, 1'b0},
        '{1'b0, 5'd0,  tce_pkg::CMD_QUERY,    4'd0,  4'd0,  1'b1, 1'b1, 1'b0},
        '{1'b0, 5'd0,  tce_pkg::CMD_QUERY,    4'd15, 4'd15, 1'b1, 1'b1, 1'b0},
        '{1'b0, 5'd0,  tce_pkg::CMD_ADD_EDGE, 4'd3,  4'd7,  1'b0, 1'b0, 1'b0},
        '{1'b0, 5'd0,  tce_pkg::CMD_ADD_EDGE, 4'd7,  4'd9,  1'b0, 1'b0, 1'b0},
        '{1'b0, 5'd0,  tce_pkg::CMD_CLOSURE,  4'd5,  4'd6,  1'b1, 1'b0, 1'b0},
        '{1'b0, 5'd0,  tce_pkg::CMD_QUERY,    4'd3,  4'd9,  1'b0, 1'b0, 1'b0},
        '{1'b0, 5'd0,  tce_pkg::CMD_QUERY,    4'd9,  4'd3,  1'b0, 1'b0, 1'b0},
        '{1'b1, 5'd4,  tce_pkg::CMD_ADD_EDGE, 4'd0,  4'd0,  1'b0, 1'b0, 1'b0},
        '{1'b0, 5'd0,  tce_pkg::CMD_ADD_EDGE, 4'd4,  4'd0,  1'b1, 1'b0, 1'b1},
        '{1'b0, 5'd0,  tce_pkg::CMD_QUERY,    4'd0,  4'd4,  1'b1, 1'b0, 1'b1},
        '{1'b0, 5'd0,  tce_pkg::CMD_ADD_EDGE, 4'd3,  4'd1,  1'b0, 1'b0, 1'b0},
        '{1'b0, 5'd0,  tce_pkg::CMD_CLOSURE,  4'd0,  4'd0,  1'b1, 1'b0, 1'b0},
        '{1'b0, 5'd0,  tce_pkg::CMD_QUERY,    4'd15, 4'd0,  1'b1, 1'b0, 1'b1},
        '{1'b1, 5'd0,  tce_pkg::CMD_ADD_EDGE, 4'd0,  4'd0,  1'b0, 1'b0, 1'b0},
        '{1'b0, 5'd0,  tce_pkg::CMD_ADD_EDGE, 4'd0,  4'd0,  1'b1, 1'b0, 1'b1},
        '{1'b0, 5'd0,  tce_pkg::CMD_CLOSURE,  4'd0,  4'd0,  1'b1, 1'b0, 1'b0},
        '{1'b0, 5'd0,  tce_pkg::CMD_QUERY,    4'd0,  4'd0,  1'b1, 1'b0, 1'b1},
        '{1'b1, 5'd31, tce_pkg::CMD_ADD_EDGE, 4'd0,  4'd0,  1'b0, 1'b0, 1'b0},
        '{1'b0, 5'd0,  tce_pkg::CMD_QUERY,    4'd15, 4'd15, 1'b0, 1'b0, 1'b0},
        '{1'b0, 5'd0,  tce_pkg::CMD_QUERY,    4'd3,  4'd7,  1'b0, 1'b0, 1'b0},
        '{1'b0, 5'd0,  tce_pkg::CMD_ADD_EDGE, 4'd10, 4'd5,  1'b0, 1'b0, 1'b0}
    };

    transitive_closure_engine_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_src_vertex   (i_src_vertex),
        .i_dst_vertex   (i_dst_vertex),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_edge_present (o_edge_present),
        .o_status       (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int vertices_in_use();
        return (vertex_reg > tce_pkg::VCOUNT_MAX) ? tce_pkg::MAX_VERTICES : int'(vertex_reg);
    endfunction

    // Apply one command to the shadow graph and return the word it answers with
    function automatic t_answer apply_command(input logic [tce_pkg::CMD_W-1:0] cmd,
                                              input logic [tce_pkg::IDX_W-1:0] src,
                                              input logic [tce_pkg::IDX_W-1:0] dst);
        t_answer                   ans;
        int                        n;
        logic [tce_pkg::ROW_W-1:0] cols;
        logic [tce_pkg::ROW_W-1:0] pivot;
        n   = vertices_in_use();
        ans = '0;
        case (cmd) inside
            tce_pkg::CMD_CLOSURE: begin
                cols = (n >= tce_pkg::ROW_W) ? '1
                     : ((tce_pkg::ROW_W'(1) << n) - tce_pkg::ROW_W'(1));
                for (int i = 0; i < n; i++) reach_rows[i][i] = 1'b1;
                // only columns below n propagate; stale bits above stay put
                for (int k = 0; k < n; k++) begin
                    pivot = reach_rows[k] & cols;
                    for (int i = 0; i < n; i++)
                        if (reach_rows[i][k]) reach_rows[i] |= pivot;
                end
            end
            tce_pkg::CMD_ADD_EDGE, tce_pkg::CMD_QUERY: begin
                if (int'(src) >= n || int'(dst) >= n) begin
                    ans.status = 1'b1;
                end else if (cmd == tce_pkg::CMD_ADD_EDGE) begin
                    reach_rows[src][dst] = 1'b1;
                end else begin
                    ans.edge_present = reach_rows[src][dst];
                end
            end
            default: ans.status = 1'b1;
        endcase
        return ans;
    endfunction

    task automatic send_command(input logic [tce_pkg::CMD_W-1:0] cmd,
                                input logic [tce_pkg::IDX_W-1:0] src,
                                input logic [tce_pkg::IDX_W-1:0] dst, input bit known,
                                input t_answer typed);
        t_answer ans;
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_src_vertex <= src;
        i_dst_vertex <= dst;
        do @(posedge i_clk); while (!o_in_ready);
        ans = apply_command(cmd, src, dst);
        pending_answers.push_back(known ? typed : ans);
        words_sent++;
        if (cmd == tce_pkg::CMD_CLOSURE) closures++;
        if (ans.status) flagged++;
        // random gap before the next word, with calm stretches between bursts
        if (calm_left > 0) begin
            calm_left--;
        end else if (stall_on && $urandom_range(0, 2) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end else if ($urandom_range(0, 5) == 0) begin
            calm_left = $urandom_range(10, 30);
        end
    endtask

    task automatic drain_answers();
        i_in_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_vertex_count(input logic [tce_pkg::CNT_W-1:0] value);
        drain_answers();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        vertex_reg = value;
    endtask

    function automatic logic [tce_pkg::IDX_W-1:0] pick_vertex();
        int n;
        n = vertices_in_use();
        if (n > 0 && $urandom_range(0, 9) < 8)
            return tce_pkg::IDX_W'($urandom_range(0, n - 1));
        return tce_pkg::IDX_W'($urandom_range(0, tce_pkg::MAX_VERTICES - 1));
    endfunction

    // Receiver side: hold ready low in bursts while stalling is allowed
    initial begin
        @(posedge i_clk);
        forever begin
            if (stall_on && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            words_seen++;
            if (pending_answers.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected word, expected none, got edge_present %0b status %0b",
                         $time, o_edge_present, o_status);
            end else begin
                want = pending_answers.pop_front();
                if (o_edge_present !== want.edge_present) begin
                    mismatches++;
                    $display("%0t: edge_present expected %0b got %0b",
                             $time, want.edge_present, o_edge_present);
                end
                if (o_status !== want.status) begin
                    mismatches++;
                    $display("%0t: status expected %0b got %0b", $time, want.status, o_status);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_transitive_closure_engine_top NOT OK");
            $finish;
        end
    end

    initial begin
        logic [tce_pkg::CNT_W-1:0] phase_counts [PHASES];
        logic [tce_pkg::CMD_W-1:0] cmd;
        int                        pick;
        phase_counts = '{5'd16, 5'd1, 5'd2, 5'd0, 5'd31, 5'd5, 5'd17, 5'd9,
                         5'd0, 5'd0, 5'd0, 5'd16};
        for (int i = 0; i < tce_pkg::MAX_VERTICES; i++) reach_rows[i] = '0;
        vertex_reg = tce_pkg::VCOUNT_RESET;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_script[r]) begin
            if (directed_script[r].is_cfg)
                write_vertex_count(directed_script[r].count);
            else
                send_command(directed_script[r].cmd, directed_script[r].src,
                             directed_script[r].dst, directed_script[r].known,
                             '{directed_script[r].present, directed_script[r].status});
        end

        for (int p = 0; p < PHASES; p++) begin
            // a few phases take a random count inside the legal range
            if (p >= 8 && p < PHASES - 1)
                phase_counts[p] = tce_pkg::CNT_W'($urandom_range(1, 16));
            if (p == PHASES - 1) begin
                drain_answers();
                stall_on  = 1'b0;
                calm_left = 0;
            end
            write_vertex_count(phase_counts[p]);
            for (int j = 0; j < PHASE_ITEMS; j++) begin
                pick = $urandom_range(0, 99);
                if (pick < 40)      cmd = tce_pkg::CMD_ADD_EDGE;
                else if (pick < 48) cmd = tce_pkg::CMD_CLOSURE;
                else if (pick < 95) cmd = tce_pkg::CMD_QUERY;
                else                cmd = CMD_UNUSED;
                send_command(cmd, pick_vertex(), pick_vertex(), 1'b0, '0);
            end
        end

        i_in_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("sent %0d commands (%0d closures, %0d flagged), checked %0d result words",
                 words_sent, closures, flagged, words_seen);
        $display("vertex counts swept from 0 to 31 with stalls on both sides, %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("tb_transitive_closure_engine_top OK");
        else
            $display("tb_transitive_closure_engine_top NOT OK");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/tce_pkg.sv
hdl/transitive_closure_engine_top.sv
hdl/tce_checker.sv
tb/tb_transitive_closure_engine_top.sv
